// ===== rtl/utf8s_pkg.sv =====
// utf8s_pkg: shared types, constants and the byte classifier of the UTF-8 sanitizer
// no dependencies; used by utf8s_front, utf8s_back and utf8_sanitizer_top
package utf8s_pkg;

  // one input item
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } utf8s_in_t;

  // one result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
    logic       end_of_message;
  } utf8s_out_t;

  // per-byte classification: sequence length as a lead byte, second-byte window,
  // continuation flag
  typedef struct packed {
    logic [2:0] need;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       is_cont;
  } utf8s_cls_t;

  // queue entry between front and back
  typedef struct packed {
    utf8s_in_t  item;
    utf8s_cls_t cls;
  } utf8s_ent_t;

  // replacement character U+FFFD, first byte at index 0
  localparam logic [2:0][7:0] REPL_SEQ = {8'hBD, 8'hBF, 8'hEF};

  // Unicode Table 3-7 lead byte decode
  function automatic utf8s_cls_t utf8s_classify(input logic [7:0] b);
    utf8s_cls_t c;
    c.need    = 3'd0;
    c.lo      = 8'h80;
    c.hi      = 8'hBF;
    c.is_cont = (b >= 8'h80) && (b <= 8'hBF);
    if (b < 8'h80) begin
      c.need = 3'd1;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      c.need = 3'd2;
    end else if (b == 8'hE0) begin
      c.need = 3'd3;
      c.lo   = 8'hA0;
    end else if (b >= 8'hE1 && b <= 8'hEC) begin
      c.need = 3'd3;
    end else if (b == 8'hED) begin
      c.need = 3'd3;
      c.hi   = 8'h9F;
    end else if (b == 8'hEE || b == 8'hEF) begin
      c.need = 3'd3;
    end else if (b == 8'hF0) begin
      c.need = 3'd4;
      c.lo   = 8'h90;
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      c.need = 3'd4;
    end else if (b == 8'hF4) begin
      c.need = 3'd4;
      c.hi   = 8'h8F;
    end
    return c;
  endfunction

endpackage

// ===== rtl/utf8s_front.sv =====
// utf8s_front: input acceptance, byte classification and a two-entry queue
// depends on utf8s_pkg
module utf8s_front import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  utf8s_in_t  in_data_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output utf8s_ent_t q_data_o
);

  utf8s_ent_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // queue handshakes
  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, classified on the way in
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].item <= in_data_i;
      mem_q[wr_ptr_q].cls  <= utf8s_classify(in_data_i.byte_in);
    end
  end

endmodule

// ===== rtl/utf8s_back.sv =====
// utf8s_back: sequence scanner, replacement sequencer and output register
// depends on utf8s_pkg; fed by utf8s_front
module utf8s_back import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  utf8s_ent_t q_data_i,
  input  logic       replace_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output utf8s_out_t out_data_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_e;

  state_e                state_q, state_d;
  logic [3:0][7:0]       buf_q, buf_d;
  utf8s_cls_t [3:0]      cls_q, cls_d;
  logic [2:0]            len_q, len_d;
  logic                  last_q, last_d;
  logic                  rep_mode_q, rep_mode_d;
  logic [1:0]            emit_idx_q, emit_idx_d;
  logic [2:0]            emit_num_q, emit_num_d;
  logic [7:0]            pend_q, pend_d;
  logic                  pend_valid_q, pend_valid_d;
  utf8s_out_t            out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic       out_free;
  logic       adv;
  logic [2:0] need;
  logic       b1_ok;
  logic       bad;
  logic       too_short;
  logic [2:0] take;
  logic [2:0] src;
  logic [7:0] emit_byte;

  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign adv         = !pend_valid_q || out_free;

  // classify the held prefix
  always_comb begin
    need  = cls_q[0].need;
    b1_ok = (buf_q[1] >= cls_q[0].lo) && (buf_q[1] <= cls_q[0].hi);
    bad   = (need == 3'd0)
         || ((len_q >= 3'd2) && (need >= 3'd2) && !b1_ok)
         || ((len_q >= 3'd3) && (need >= 3'd3) && !cls_q[2].is_cont)
         || ((len_q >= 3'd4) && (need >= 3'd4) && !cls_q[3].is_cont);
    too_short = (len_q < need);
  end

  // byte produced by the current emit step
  assign emit_byte = rep_mode_q ? REPL_SEQ[emit_idx_q] : buf_q[emit_idx_q];

  // next-state logic
  always_comb begin
    state_d      = state_q;
    buf_d        = buf_q;
    cls_d        = cls_q;
    len_d        = len_q;
    last_d       = last_q;
    rep_mode_d   = rep_mode_q;
    emit_idx_d   = emit_idx_q;
    emit_num_d   = emit_num_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    take         = 3'd1;
    src          = 3'd0;

    unique case (state_q)
      ST_IDLE: begin
        // append the new byte to the held prefix
        if (q_valid_i) begin
          buf_d[len_q[1:0]] = q_data_i.item.byte_in;
          cls_d[len_q[1:0]] = q_data_i.cls;
          len_d             = len_q + 3'd1;
          last_d            = q_data_i.item.last_in;
          state_d           = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((len_q == 3'd0) || (!bad && too_short && !last_q)) begin
          // step done: flush the pending byte as the final result
          if (!pend_valid_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_d        = '{byte_out: pend_q, last_out: 1'b1, end_of_message: last_q};
            out_valid_d  = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (bad || too_short) begin
          // first held byte is bad
          if (replace_i) begin
            rep_mode_d = 1'b1;
            emit_num_d = 3'd3;
            emit_idx_d = 2'd0;
            state_d    = ST_EMIT;
          end else begin
            take = 3'd1;
            for (int i = 0; i < 4; i++) begin
              src = 3'(i) + take;
              if (src < 3'd4) begin
                buf_d[i] = buf_q[src[1:0]];
                cls_d[i] = cls_q[src[1:0]];
              end
            end
            len_d = len_q - take;
          end
        end else begin
          // complete well-formed sequence
          rep_mode_d = 1'b0;
          emit_num_d = need;
          emit_idx_d = 2'd0;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (adv) begin
          if (pend_valid_q) begin
            out_d       = '{byte_out: pend_q, last_out: 1'b0, end_of_message: 1'b0};
            out_valid_d = 1'b1;
          end
          pend_d       = emit_byte;
          pend_valid_d = 1'b1;
          if ({1'b0, emit_idx_q} == emit_num_q - 3'd1) begin
            // sequence done: drop it from the prefix and rescan
            take = rep_mode_q ? 3'd1 : emit_num_q;
            for (int i = 0; i < 4; i++) begin
              src = 3'(i) + take;
              if (src < 3'd4) begin
                buf_d[i] = buf_q[src[1:0]];
                cls_d[i] = cls_q[src[1:0]];
              end
            end
            len_d   = len_q - take;
            state_d = ST_SCAN;
          end else begin
            emit_idx_d = emit_idx_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_q        <= 3'd0;
      last_q       <= 1'b0;
      rep_mode_q   <= 1'b0;
      emit_idx_q   <= 2'd0;
      emit_num_q   <= 3'd1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      buf_q        <= '0;
      cls_q        <= '0;
      pend_q       <= 8'd0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      last_q       <= last_d;
      rep_mode_q   <= rep_mode_d;
      emit_idx_q   <= emit_idx_d;
      emit_num_q   <= emit_num_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      buf_q        <= buf_d;
      cls_q        <= cls_d;
      pend_q       <= pend_d;
      out_q        <= out_d;
    end
  end

  // at most three bytes are held between items
  a_held_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (len_q != 3'd4))
    else $error("held prefix longer than three bytes while idle");

  // nothing is left pending once a step has closed
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending byte left over after step end");

  // pass-through never reads beyond the held prefix
  a_emit_in_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !rep_mode_q) |-> (emit_num_q <= len_q))
    else $error("emit runs past held prefix");

  // a message end is only flagged on a step's final byte
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.end_of_message) |-> out_q.last_out)
    else $error("end of message without last flag");

endmodule

// ===== rtl/utf8_sanitizer_top.sv =====
// utf8_sanitizer_top: UTF-8 stream sanitizer, front queue plus back scanner
// depends on utf8s_pkg, utf8s_front and utf8s_back

// Bytes of a message enter one per transfer on the input channel; well-formed UTF-8
// sequences leave unchanged and each bad byte becomes EF BF BD (or is dropped when the
// replace register is 0). Input transfers land in a two-entry queue, so the input side
// keeps taking bytes while the scanner works, until the queue is full. The scanner
// handles one byte at a time: it takes the byte from the queue, scans the held prefix,
// and emits each output byte in turn, rescanning after each sequence, so a byte that
// resolves a held sequence can yield up to twelve replacement bytes. The scanner's
// emit loop sets the rate. Output bytes are held back by one so the last one of each
// step carries its flags.
module utf8_sanitizer_top import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  utf8s_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output utf8s_out_t out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic       replace_q;
  logic       q_valid;
  logic       q_ready;
  utf8s_ent_t q_data;

  // replace register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      replace_q <= cfg_data_i;
    end
  end

  // input queue with classification
  utf8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  // scanner and output stage
  utf8s_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .replace_i   (replace_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
